// ===== src/ptd_pkg.sv =====
// ----------------------------------------------------------------------------
// ptd_pkg
// Shared types and constants for the periodic task dispatcher.
// ----------------------------------------------------------------------------
package ptd_pkg;

	localparam int DEF_MAX_SLOTS = 16;
	localparam int PASS_LIMIT    = 16;
	localparam int RATE_W        = 16;
	localparam int STAMP_W       = 32;
	localparam int IDX_W         = 4;
	localparam int OP_W          = 2;
	localparam int PROD_W        = RATE_W + STAMP_W;

	localparam logic [RATE_W-1:0] TICK_RATE_RESET = 16'd40000;

	localparam logic [OP_W-1:0] OP_ADD  = 2'd0;
	localparam logic [OP_W-1:0] OP_TICK = 2'd1;
	localparam logic [OP_W-1:0] OP_RUN  = 2'd2;

	// one slot word as held in the task memory
	typedef struct packed {
		logic [RATE_W-1:0]  rate;
		logic [STAMP_W-1:0] stamp;
	} ptd_word_t;

	localparam int WORD_W = $bits(ptd_word_t);

endpackage

// ===== src/ptd_ram.sv =====
// ----------------------------------------------------------------------------
// ptd_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module ptd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== src/ptd_slot_eval.sv =====
// ----------------------------------------------------------------------------
// ptd_slot_eval
// Due test for one slot word and the word to write back.
// ----------------------------------------------------------------------------
module ptd_slot_eval
	import ptd_pkg::*;
(
	input  ptd_word_t          rd_word,
	input  logic [STAMP_W-1:0] now,
	input  logic [RATE_W-1:0]  tick_rate,
	output logic               due,
	output ptd_word_t          wr_word
);

	logic [STAMP_W-1:0] elapsed;
	logic [PROD_W-1:0]  prod;

	// elapsed wraps mod 2^32
	assign elapsed = now - rd_word.stamp;
	assign prod    = PROD_W'(elapsed) * PROD_W'(rd_word.rate);

	// zero rate never due
	assign due = (rd_word.rate != '0) && (prod > PROD_W'(tick_rate));

	assign wr_word.rate  = rd_word.rate;
	assign wr_word.stamp = now;

endmodule

// ===== src/periodic_task_dispatcher_unit.sv =====
// ----------------------------------------------------------------------------
// periodic_task_dispatcher_unit
// Periodic task dispatcher: add, tick and run words on a start/busy port.
// ----------------------------------------------------------------------------
// Add and tick leave busy low and the next word may follow. A run over n tasks
// (n = min(task count, 16)) sets run_q to issue the reads; results come via
// the registered read and vld_s1, one per cycle, set by the single task memory
// read port; busy is high through the last result. Results cannot be stalled.
// Reset clears the tick counter and task count, and loads tick_rate 40000.
module periodic_task_dispatcher_unit
	import ptd_pkg::*;
#(
	parameter int MAX_SLOTS = DEF_MAX_SLOTS
) (
	input  logic              clk,
	input  logic              arst_n,
	// command port
	input  logic              start,
	output logic              busy,
	input  logic [OP_W-1:0]   operation,
	input  logic [RATE_W-1:0] task_rate,
	// configuration
	input  logic              cfg_we,
	input  logic [RATE_W-1:0] cfg_data,
	// results
	output logic              strobe,
	output logic [IDX_W-1:0]  task_index,
	output logic              due,
	output logic              last
);

	localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int CW = $clog2(MAX_SLOTS + 1);

	// architectural registers
	logic [RATE_W-1:0]  tick_rate_q;
	logic [STAMP_W-1:0] tick_counter_q;
	logic [CW-1:0]      task_count_q;

	// pass control
	logic               run_q;      // read issue phase of a pass
	logic [AW-1:0]      rd_idx_q;   // next slot to read
	logic [CW-1:0]      pass_n_q;   // slots in this pass

	// stage 1: memory read returning
	logic               vld_s1;
	logic [AW-1:0]      addr_s1;
	logic               last_s1;

	logic               accept;
	logic [CW-1:0]      pass_n;
	logic [CW-1:0]      rd_next;
	logic               rd_last;

	// memory ports
	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	ptd_word_t          ram_wdata;
	ptd_word_t          ram_rdata;
	logic [WORD_W-1:0]  ram_rdata_raw;

	logic               slot_due;
	ptd_word_t          wb_word;
	ptd_word_t          add_word;
	logic               add_ok;

	assign busy   = run_q | vld_s1;
	assign accept = start & ~busy;

	// a pass never covers more than sixteen slots
	always_comb begin
		if (32'(task_count_q) > PASS_LIMIT) begin
			pass_n = CW'(PASS_LIMIT);
		end else begin
			pass_n = task_count_q;
		end
	end

	assign rd_next = CW'(rd_idx_q) + CW'(1);
	assign rd_last = (rd_next == pass_n_q);

	// add lands in the next free slot; ignored once the table is full
	assign add_ok         = (32'(task_count_q) < MAX_SLOTS);
	assign add_word.rate  = task_rate;
	assign add_word.stamp = '0;

	// write port: add when idle, stamp write-back during a pass.
	// Write-back to slot i overlaps the read of slot i+1, so never the
	// same entry; a following pass reads only after the last write lands.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr_s1;
		ram_wdata = wb_word;
		if (vld_s1) begin
			ram_we = slot_due;
		end else if (accept && operation == OP_ADD && add_ok) begin
			ram_we    = 1'b1;
			ram_waddr = AW'(task_count_q);
			ram_wdata = add_word;
		end
	end

	ptd_ram #(
		.WIDTH (WORD_W),
		.DEPTH (MAX_SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (rd_idx_q),
		.rdata (ram_rdata_raw)
	);

	assign ram_rdata = ptd_word_t'(ram_rdata_raw);

	ptd_slot_eval u_eval (
		.rd_word   (ram_rdata),
		.now       (tick_counter_q),
		.tick_rate (tick_rate_q),
		.due       (slot_due),
		.wr_word   (wb_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_rate_q    <= TICK_RATE_RESET;
			tick_counter_q <= '0;
			task_count_q   <= '0;
			run_q          <= 1'b0;
			rd_idx_q       <= '0;
			pass_n_q       <= '0;
			vld_s1         <= 1'b0;
			addr_s1        <= '0;
			last_s1        <= 1'b0;
		end else begin
			if (cfg_we) begin
				tick_rate_q <= cfg_data;
			end

			// read issue, one slot a cycle
			vld_s1  <= run_q;
			addr_s1 <= rd_idx_q;
			last_s1 <= rd_last;
			if (run_q) begin
				rd_idx_q <= AW'(rd_next);
				if (rd_last) begin
					run_q <= 1'b0;
				end
			end

			if (accept) begin
				case (operation)
					OP_ADD: begin
						if (add_ok) begin
							task_count_q <= task_count_q + CW'(1);
						end
					end
					OP_TICK: begin
						tick_counter_q <= tick_counter_q + STAMP_W'(1);
					end
					OP_RUN: begin
						// empty table: no pass, no results
						if (pass_n != '0) begin
							run_q    <= 1'b1;
							rd_idx_q <= '0;
							pass_n_q <= pass_n;
						end
					end
					default: begin
						// unused code: no effect
					end
				endcase
			end
		end
	end

	assign strobe     = vld_s1;
	assign task_index = IDX_W'(addr_s1);
	assign due        = vld_s1 & slot_due;
	assign last       = vld_s1 & last_s1;

endmodule

// ===== verif/periodic_task_dispatcher_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// periodic_task_dispatcher_unit_tb
// Self-checking bench for the periodic task dispatcher. Add, tick and run
// words go in on the start/busy port. A local copy of the dispatcher state
// predicts every due report, and each strobed result is checked in order
// against it. Directed words come first, then random traffic under three
// tick_rate settings and three levels of sender idling.
// ----------------------------------------------------------------------------
module periodic_task_dispatcher_unit_tb
	import ptd_pkg::*;
();

	localparam int HALF_PERIOD   = 6;
	localparam int SLOTS         = DEF_MAX_SLOTS;
	// spare margin after the owed reports, before waiting on busy
	localparam int SETTLE_CYCLES = 4;
	// cycles without any accepted word or report before giving up
	localparam int STALL_LIMIT   = 2000;

	// operation code 3 is unused by the block and must do nothing
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	// one report of a run pass
	typedef struct packed {
		logic [IDX_W-1:0] slot;
		logic             due;
		logic             last;
	} due_report_t;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [OP_W-1:0]   operation;
	logic [RATE_W-1:0] task_rate;
	logic              cfg_we;
	logic [RATE_W-1:0] cfg_data;
	logic              strobe;
	logic [IDX_W-1:0]  task_index;
	logic              due;
	logic              last;

	periodic_task_dispatcher_unit #(
		.MAX_SLOTS (SLOTS)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.operation  (operation),
		.task_rate  (task_rate),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.strobe     (strobe),
		.task_index (task_index),
		.due        (due),
		.last       (last)
	);

	always #HALF_PERIOD clk = ~clk;

	// ------------------------------------------------------------------
	// Local copy of the dispatcher state
	// ------------------------------------------------------------------
	logic [RATE_W-1:0]  m_tick_rate;
	logic [STAMP_W-1:0] m_ticks;
	int                 m_count;
	logic [RATE_W-1:0]  m_rate  [SLOTS];
	logic [STAMP_W-1:0] m_stamp [SLOTS];

	// reports still owed by the block, oldest first
	due_report_t due_reports [$];

	int n_errors;
	int idle_pct;     // chance in a hundred that the sender idles a cycle
	int stall_cycles;

	// Apply one accepted word to the local state and queue the reports it
	// causes. Due when elapsed * rate > tick_rate, product taken at full
	// width; a zero rate is never due. Elapsed wraps at 32 bits.
	function automatic void dispatch_model(input logic [OP_W-1:0] op,
			input logic [RATE_W-1:0] rate);
		int                 n;
		logic [STAMP_W-1:0] elapsed;
		logic [PROD_W-1:0]  prod;
		due_report_t        rep;
		case (op)
			OP_ADD: begin
				// full table: word dropped
				if (m_count < SLOTS) begin
					m_rate[m_count]  = rate;
					m_stamp[m_count] = '0;
					m_count++;
				end
			end
			OP_TICK: begin
				m_ticks = m_ticks + 1'b1;
			end
			OP_RUN: begin
				n = (m_count > PASS_LIMIT) ? PASS_LIMIT : m_count;
				for (int i = 0; i < n; i++) begin
					elapsed  = m_ticks - m_stamp[i];
					prod     = PROD_W'(elapsed) * PROD_W'(m_rate[i]);
					rep.slot = IDX_W'(i);
					rep.due  = (m_rate[i] != '0) && (prod > PROD_W'(m_tick_rate));
					rep.last = (i == n - 1);
					if (rep.due)
						m_stamp[i] = m_ticks;
					due_reports.push_back(rep);
				end
			end
			default: begin
				// unused code: no state change, no reports
			end
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Sender: one word per call. Inputs move on the falling edge; the word
	// is taken at the first rising edge with busy low. Start stays high
	// across back-to-back words and only drops on an idle cycle.
	// ------------------------------------------------------------------
	task automatic send_word(input logic [OP_W-1:0] op, input logic [RATE_W-1:0] rate);
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			start     <= 1'b0;
			operation <= OP_W'($urandom);
			task_rate <= RATE_W'($urandom);
		end
		@(negedge clk);
		start     <= 1'b1;
		operation <= op;
		task_rate <= rate;
		do
			@(posedge clk);
		while (busy);
		dispatch_model(op, rate);
	endtask

	// Hold off until every owed report is in and the block has settled.
	// Needed before a register write, since a run over no tasks leaves
	// nothing in the queue to wait on.
	task automatic wait_drained();
		@(negedge clk);
		start <= 1'b0;
		while (due_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic write_tick_rate(input logic [RATE_W-1:0] value);
		wait_drained();
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= value;
		@(negedge clk);
		cfg_we   <= 1'b0;
		m_tick_rate = value;
	endtask

	// ------------------------------------------------------------------
	// Result checker: reports cannot be held off, so every strobe is
	// taken and matched against the oldest prediction.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : check_reports
		due_report_t want;
		if (arst_n && strobe) begin
			if (due_reports.size() == 0) begin
				$error("report with none owed: task_index %0d due %0b last %0b",
					task_index, due, last);
				n_errors++;
			end else begin
				want = due_reports.pop_front();
				if (task_index !== want.slot) begin
					$error("task_index: expected %0d, got %0d", want.slot, task_index);
					n_errors++;
				end
				if (due !== want.due) begin
					$error("due: expected %0b, got %0b", want.due, due);
					n_errors++;
				end
				if (last !== want.last) begin
					$error("last: expected %0b, got %0b", want.last, last);
					n_errors++;
				end
			end
		end
	end

	// Watchdog: any accepted word or report restarts the count.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe)
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// run on an empty table gives nothing; unused code gives nothing
	task automatic test_empty_dispatch();
		send_word(OP_RUN, RATE_W'($urandom));
		send_word(OP_UNUSED, RATE_W'($urandom));
	endtask

	// zero, top and bottom rates; run before and after one tick at the
	// reset tick_rate, so only the fastest task comes due
	task automatic test_first_tasks();
		send_word(OP_ADD, 16'd0);
		send_word(OP_ADD, 16'hFFFF);
		send_word(OP_ADD, 16'd1);
		send_word(OP_RUN, RATE_W'($urandom));
		send_word(OP_TICK, RATE_W'($urandom));
		send_word(OP_RUN, RATE_W'($urandom));
	endtask

	// tick_rate of zero: any nonzero rate with time elapsed is due
	task automatic test_zero_tick_rate();
		write_tick_rate(16'd0);
		send_word(OP_TICK, RATE_W'($urandom));
		send_word(OP_RUN, RATE_W'($urandom));
	endtask

	// fill the remaining slots, then one add past the end which is dropped,
	// then a full sixteen-report pass with last on slot 15
	task automatic test_full_table();
		logic [RATE_W-1:0] rates [13];
		rates = '{16'hFFFF, 16'h8000, 16'd1, 16'd2, 16'd3, 16'd100, 16'd1000,
			16'd40001, 16'h5555, 16'hAAAA, 16'd20000, 16'd0, 16'd7};
		write_tick_rate(16'hFFFF);
		for (int i = 0; i < 11; i++)
			send_word(OP_ADD, rates[i]);
		send_word(OP_ADD, RATE_W'($urandom));
		send_word(OP_ADD, RATE_W'($urandom));
		send_word(OP_ADD, 16'hFFFF);
		send_word(OP_RUN, RATE_W'($urandom));
	endtask

	// random words at one tick_rate; ticks and runs make up most of it,
	// adds (dropped once full) and the unused code are noise
	task automatic test_random_traffic(input int pct, input logic [RATE_W-1:0] rate_cfg,
			input int n_words);
		int              counted;
		int              sel;
		logic [OP_W-1:0] op;
		counted = 0;
		write_tick_rate(rate_cfg);
		idle_pct = pct;
		while (counted < n_words) begin
			sel = $urandom_range(99);
			if (sel < 45)
				op = OP_TICK;
			else if (sel < 75)
				op = OP_RUN;
			else if (sel < 88)
				op = OP_ADD;
			else
				op = OP_UNUSED;
			// now and then let the block run dry before the next word
			if ($urandom_range(24) == 0)
				wait_drained();
			send_word(op, RATE_W'($urandom));
			counted++;
		end
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		clk       = 1'b0;
		arst_n    <= 1'b0;
		start     <= 1'b0;
		operation <= '0;
		task_rate <= '0;
		cfg_we    <= 1'b0;
		cfg_data  <= '0;
		n_errors     = 0;
		idle_pct     = 0;
		stall_cycles = 0;
		m_tick_rate  = TICK_RATE_RESET;
		m_ticks      = '0;
		m_count      = 0;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed words, no idling
		test_empty_dispatch();
		test_first_tasks();
		test_zero_tick_rate();
		test_full_table();

		// random traffic: sender idles 22 %, then 50 %, then never
		test_random_traffic(22, 16'($urandom_range(1, 200)), 68);
		test_random_traffic(50, 16'hFFFF, 68);
		test_random_traffic(0, 16'd1, 68);

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (n_errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
